// ===== hdl/eam_pkg.sv =====
// ----------------------------------------------------------------------------
// Exclusive access monitor package
// Shared widths, command and status codes, and controller interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package eam_pkg;

    localparam int CMD_W       = 2;
    localparam int TID_W       = 3;
    localparam int ADDR_W      = 64;
    localparam int STATUS_W    = 2;
    localparam int THREADS_DEF = 8;

    // Commands carried by an input item.
    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_CHECK   = 2'd1,
        CMD_UNLOCK  = 2'd2,
        CMD_NOTIFY  = 2'd3
    } cmd_t;

    // Status codes carried by a result item.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE   = 2'd0,
        STATUS_LOCKED = 2'd1,
        STATUS_FAILED = 2'd2,
        STATUS_BUSY   = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the incoming item
        logic exec;     // apply the captured item and register its status
    } eam_ctrl_t;

endpackage : eam_pkg

`default_nettype wire

// ===== hdl/eam_req_if.sv =====
// ----------------------------------------------------------------------------
// Exclusive access monitor request channel
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
`default_nettype none

interface eam_req_if
    import eam_pkg::*;
();

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [TID_W-1:0]    thread_id;
    logic [ADDR_W-1:0]   address;

    modport source (output valid, output cmd, output thread_id, output address,
                    input ready);
    modport sink   (input valid, input cmd, input thread_id, input address,
                    output ready);

endinterface : eam_req_if

`default_nettype wire

// ===== hdl/eam_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Exclusive access monitor response channel
// Valid/ready channel that carries one status item.
// ----------------------------------------------------------------------------
`default_nettype none

interface eam_rsp_if
    import eam_pkg::*;
();

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);

endinterface : eam_rsp_if

`default_nettype wire

// ===== hdl/eam_ctrl.sv =====
// ----------------------------------------------------------------------------
// Exclusive access monitor controller
// Sequences capture and execution of items and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module eam_ctrl
    import eam_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output eam_ctrl_t      ctrl
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The result register can take a new status when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl.load      = 1'b0;
        ctrl.exec      = 1'b0;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    ctrl.exec      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule : eam_ctrl

`default_nettype wire

// ===== hdl/eam_datapath.sv =====
// ----------------------------------------------------------------------------
// Exclusive access monitor datapath
// Reservation table, lock state, item capture and result status register.
// ----------------------------------------------------------------------------
`default_nettype none

module eam_datapath
    import eam_pkg::*;
#(
    parameter int THREADS = THREADS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire eam_ctrl_t           ctrl,
    input  wire logic [CMD_W-1:0]    cmd,
    input  wire logic [TID_W-1:0]    thread_id,
    input  wire logic [ADDR_W-1:0]   address,
    output logic [STATUS_W-1:0]      status
);

    cmd_t                cmd_reg;
    logic [TID_W-1:0]    tid_reg;
    logic [ADDR_W-1:0]   addr_reg;

    logic [THREADS-1:0]  res_valid_reg;
    logic [THREADS-1:0]  res_valid_next;
    logic [ADDR_W-1:0]   res_addr_reg [THREADS];
    logic                lock_taken_reg;
    logic                lock_taken_next;
    logic [TID_W-1:0]    lock_owner_reg;
    logic [TID_W-1:0]    lock_owner_next;
    status_t             status_reg;
    status_t             status_next;

    logic [THREADS-1:0]  sel;       // entry belongs to the requesting thread
    logic [THREADS-1:0]  addr_eq;   // entry address equals the item address
    logic                in_range;
    logic                is_owner;
    logic                busy;
    logic                res_hit;
    logic                write_res;

    // Item capture; payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= cmd_t'(cmd);
            tid_reg  <= thread_id;
            addr_reg <= address;
        end
    end

    // Per-entry select and address compare, all entries in parallel.
    for (genvar i = 0; i < THREADS; i++)
    begin : g_entry
        assign sel[i]     = (int'(tid_reg) == i);
        assign addr_eq[i] = (res_addr_reg[i] == addr_reg);

        always_ff @(posedge clk)
        begin
            if (write_res && sel[i])
            begin
                res_addr_reg[i] <= addr_reg;
            end
        end
    end

    assign in_range = (int'(tid_reg) < THREADS);
    assign is_owner = lock_taken_reg && (lock_owner_reg == tid_reg);
    assign busy     = lock_taken_reg && (lock_owner_reg != tid_reg);
    assign res_hit  = |(sel & res_valid_reg & addr_eq);

    always_comb
    begin
        res_valid_next  = res_valid_reg;
        lock_taken_next = lock_taken_reg;
        lock_owner_next = lock_owner_reg;
        status_next     = STATUS_DONE;
        write_res       = 1'b0;
        if (!in_range)
        begin
            status_next = STATUS_DONE;
        end
        else if (busy)
        begin
            status_next = STATUS_BUSY;
        end
        else
        begin
            unique case (cmd_reg)
                CMD_ACQUIRE:
                begin
                    write_res      = ctrl.exec;
                    res_valid_next = res_valid_reg | sel;
                    if (is_owner)
                    begin
                        lock_taken_next = 1'b0;
                    end
                end
                CMD_CHECK:
                begin
                    if (res_hit)
                    begin
                        lock_taken_next = 1'b1;
                        lock_owner_next = tid_reg;
                        status_next     = STATUS_LOCKED;
                    end
                    else
                    begin
                        if (is_owner)
                        begin
                            lock_taken_next = 1'b0;
                        end
                        status_next = STATUS_FAILED;
                    end
                end
                CMD_UNLOCK:
                begin
                    if (is_owner)
                    begin
                        lock_taken_next = 1'b0;
                    end
                end
                CMD_NOTIFY:
                begin
                    // Another thread's store to the same address kills its link.
                    res_valid_next = res_valid_reg & ~(addr_eq & ~sel);
                    if (is_owner)
                    begin
                        lock_taken_next = 1'b0;
                    end
                end
                default:
                begin
                    status_next = STATUS_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= '0;
            lock_taken_reg <= 1'b0;
            lock_owner_reg <= '0;
        end
        else if (ctrl.exec)
        begin
            res_valid_reg  <= res_valid_next;
            lock_taken_reg <= lock_taken_next;
            lock_owner_reg <= lock_owner_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            status_reg <= status_next;
        end
    end

    assign status = status_reg;

endmodule : eam_datapath

`default_nettype wire

// ===== hdl/exclusive_access_monitor.sv =====
// A result item is captured, then executed into the status register when the
// output is free; execution waits only while the result register is full.
// The controller takes no new item while one is captured but not executed;
// the next item is taken while a result still waits.
// Reset: rst_n clears all reservations and the lock at once; no clearing pass.
// ----------------------------------------------------------------------------
// Exclusive access monitor
// Global monitor for load-linked / store-conditional with one lock owner.
// ----------------------------------------------------------------------------
`default_nettype none

// Each thread holds at most one reservation: a valid bit and an address.
// An acquire records it, a check compares it against the item address and
// takes the lock on a match, an unlock frees the lock for its owner, and a
// notify clears the reservations of every other thread on the same address.
// While one thread holds the lock, an item from any other thread below THREADS
// returns busy and leaves all state untouched. Thread numbers at or above
// THREADS are ignored and return done.
//
// The controller captures one item, then executes it against the reservation
// table in the datapath as soon as the result register can take the status.
module exclusive_access_monitor
    import eam_pkg::*;
#(
    parameter int THREADS = THREADS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    eam_req_if.sink    req,
    eam_rsp_if.source  rsp
);

    eam_ctrl_t ctrl;

    // Control sequencer: handshakes and result valid flag.
    eam_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctrl      (ctrl)
    );

    // Reservation table, lock state and result status.
    eam_datapath #(
        .THREADS (THREADS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cmd       (req.cmd),
        .thread_id (req.thread_id),
        .address   (req.address),
        .status    (rsp.status)
    );

endmodule : exclusive_access_monitor

`default_nettype wire

// ===== hdl/eam_checker.sv =====
// ----------------------------------------------------------------------------
// Exclusive access monitor checker
// Port-level assertions on item flow, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module eam_checker
    import eam_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_ready,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire logic [STATUS_W-1:0] status
);

    logic       req_fire;
    logic       rsp_fire;
    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    assign req_fire = req_valid && req_ready;
    assign rsp_fire = rsp_valid && rsp_ready;

    // Items accepted whose result has not yet been delivered.
    always_comb
    begin
        pend_next = pend_reg;
        if (req_fire && !rsp_fire)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!req_fire && rsp_fire)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
        else $error("result changed or dropped while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req_ready)
        else $error("item accepted while the previous one is still executing");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("result shown with no item outstanding");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two items outstanding");

endmodule : eam_checker

bind exclusive_access_monitor eam_checker u_eam_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status)
);

`default_nettype wire
